>>> sv/ced_pkg.sv
// Package for the case-insensitive edit distance block.
// Holds widths, request codes, the cell link type and the letter compare.
// No dependencies.
`default_nettype none

package ced_pkg;

  localparam int MAX_LEN = 64;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int CH_W    = 8;
  localparam int KIND_W  = 2;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

  typedef struct packed {
    logic            tok;
    logic [LEN_W-1:0] new_v;
    logic [LEN_W-1:0] old_v;
    logic [CH_W-1:0]  ch;
  } link_t;

  function automatic logic is_letter(input logic [CH_W-1:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic letters_match(input logic [CH_W-1:0] a,
                                         input logic [CH_W-1:0] b);
    return is_letter(a) && is_letter(b) && ((a & 8'hDF) == (b & 8'hDF));
  endfunction

endpackage

`default_nettype wire

>>> sv/ced_cell.sv
// One column of the edit distance row: a first-word byte and its DP entry.
// Updates when the wavefront token passes and hands it to the next cell.
// Depends on ced_pkg.
`default_nettype none

module ced_cell (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 clr,
  input  wire logic [ced_pkg::LEN_W-1:0] col,
  input  wire logic                 wr_en,
  input  wire logic [ced_pkg::CH_W-1:0]  wr_ch,
  input  wire ced_pkg::link_t       lnk_i,
  output ced_pkg::link_t            lnk_o
);
  import ced_pkg::*;

  logic [CH_W-1:0]  ch_r;
  logic             loaded_r, loaded_nxt;
  logic [LEN_W-1:0] d_r, d_nxt;
  link_t            lnk_r, lnk_nxt;
  logic [LEN_W-1:0] lo;
  logic [LEN_W-1:0] cand;

  always_comb begin
    lo = lnk_i.old_v;
    if (d_r < lo) lo = d_r;
    if (lnk_i.new_v < lo) lo = lnk_i.new_v;
    cand = letters_match(ch_r, lnk_i.ch) ? lnk_i.old_v : lo + LEN_W'(1);
  end

  always_comb begin
    loaded_nxt  = loaded_r;
    d_nxt       = d_r;
    lnk_nxt     = lnk_i;
    lnk_nxt.old_v = d_r;
    if (lnk_i.tok && loaded_r) begin
      d_nxt         = cand;
      lnk_nxt.new_v = cand;
    end
    if (wr_en) loaded_nxt = 1'b1;
    if (clr) begin
      loaded_nxt = 1'b0;
      d_nxt      = col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r  <= 1'b0;
      d_r       <= col;
      lnk_r.tok <= 1'b0;
    end else begin
      loaded_r  <= loaded_nxt;
      d_r       <= d_nxt;
      lnk_r.tok <= lnk_nxt.tok;
    end
  end

  always_ff @(posedge clk) begin
    lnk_r.new_v <= lnk_nxt.new_v;
    lnk_r.old_v <= lnk_nxt.old_v;
    lnk_r.ch    <= lnk_nxt.ch;
    if (wr_en) ch_r <= wr_ch;
  end

  assign lnk_o = lnk_r;

endmodule

`default_nettype wire

>>> sv/case_insensitive_edit_distance.sv
// Top level of the case-insensitive edit distance block.
// Holds the column-zero entry, lengths and control, and a chain of ced_cell.
// Depends on ced_pkg and ced_cell.
`default_nettype none

// Load the first word with kind 0 requests, stream the second word with kind 1
// requests, then issue a kind 2 request: the distance and overflow flag appear
// on out_distance/out_overflow with out_valid high for one cycle, the cycle
// after that request, and the block is cleared for the next pair. The receiver
// cannot stall; sample the result when out_valid is high. Kind 0, kind 2 and
// dropped requests do not raise busy. A kind 1 request that is taken holds
// busy while the DP update travels one cell per cycle down the 64-cell chain
// and its last value returns to the top level. No clearing pass follows reset.
module case_insensitive_edit_distance (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output      logic                       busy,
  input  wire logic [ced_pkg::KIND_W-1:0] in_kind,
  input  wire logic [ced_pkg::CH_W-1:0]   in_ch,
  output      logic                       out_valid,
  output      logic [ced_pkg::LEN_W-1:0]  out_distance,
  output      logic                       out_overflow
);
  import ced_pkg::*;

  logic [LEN_W-1:0] first_len_r, first_len_nxt;
  logic [LEN_W-1:0] second_len_r, second_len_nxt;
  logic             ovf_r, ovf_nxt;
  logic [LEN_W-1:0] d0_r, d0_nxt;
  logic [LEN_W-1:0] dist_r, dist_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  link_t            inj_r, inj_nxt;
  logic             out_valid_r;
  logic [LEN_W-1:0] out_distance_r;
  logic             out_overflow_r;

  logic             acc;
  logic             load_go;
  logic             second_go;
  logic             fin_go;
  logic             clr;
  link_t            lnk [0:MAX_LEN];
  logic [MAX_LEN-1:0] wr_en;

  assign busy      = (cnt_r != '0);
  assign acc       = start && !busy;
  assign load_go   = acc && (in_kind == KIND_LOAD) && (second_len_r == '0)
                     && (first_len_r < LEN_W'(MAX_LEN));
  assign second_go = acc && (in_kind == KIND_SECOND) && (second_len_r < LEN_W'(MAX_LEN));
  assign fin_go    = acc && (in_kind == KIND_FINISH);
  assign clr       = fin_go;

  always_comb begin
    first_len_nxt  = first_len_r;
    second_len_nxt = second_len_r;
    ovf_nxt        = ovf_r;
    d0_nxt         = d0_r;
    dist_nxt       = dist_r;
    cnt_nxt        = busy ? cnt_r - LEN_W'(1) : cnt_r;
    inj_nxt        = inj_r;
    inj_nxt.tok    = 1'b0;
    if (lnk[MAX_LEN].tok) dist_nxt = lnk[MAX_LEN].new_v;
    if (acc && (in_kind == KIND_LOAD) && (second_len_r == '0) && !load_go)
      ovf_nxt = 1'b1;
    if (acc && (in_kind == KIND_SECOND) && !second_go)
      ovf_nxt = 1'b1;
    if (load_go) begin
      first_len_nxt = first_len_r + LEN_W'(1);
      dist_nxt      = first_len_r + LEN_W'(1);
    end
    if (second_go) begin
      second_len_nxt = second_len_r + LEN_W'(1);
      d0_nxt         = second_len_r + LEN_W'(1);
      cnt_nxt        = LEN_W'(MAX_LEN + 1);
      inj_nxt.tok    = 1'b1;
      inj_nxt.new_v  = second_len_r + LEN_W'(1);
      inj_nxt.old_v  = d0_r;
      inj_nxt.ch     = in_ch;
    end
    if (fin_go) begin
      first_len_nxt  = '0;
      second_len_nxt = '0;
      ovf_nxt        = 1'b0;
      d0_nxt         = '0;
      dist_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_len_r  <= '0;
      second_len_r <= '0;
      ovf_r        <= 1'b0;
      d0_r         <= '0;
      dist_r       <= '0;
      cnt_r        <= '0;
      inj_r.tok    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      first_len_r  <= first_len_nxt;
      second_len_r <= second_len_nxt;
      ovf_r        <= ovf_nxt;
      d0_r         <= d0_nxt;
      dist_r       <= dist_nxt;
      cnt_r        <= cnt_nxt;
      inj_r.tok    <= inj_nxt.tok;
      out_valid_r  <= fin_go;
    end
  end

  always_ff @(posedge clk) begin
    inj_r.new_v <= inj_nxt.new_v;
    inj_r.old_v <= inj_nxt.old_v;
    inj_r.ch    <= inj_nxt.ch;
    if (fin_go) begin
      out_distance_r <= dist_r;
      out_overflow_r <= ovf_r;
    end
  end

  assign lnk[0] = inj_r;

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    assign wr_en[k] = load_go && (first_len_r[IDX_W-1:0] == IDX_W'(k));
    ced_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .clr   (clr),
      .col   (LEN_W'(k + 1)),
      .wr_en (wr_en[k]),
      .wr_ch (in_ch),
      .lnk_i (lnk[k]),
      .lnk_o (lnk[k+1])
    );
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_overflow = out_overflow_r;

  a_out_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && (in_kind == KIND_FINISH)))
    else $error("result strobe without a finish request");

  a_end_on_last_count: assert property (@(posedge clk) disable iff (!rst_n)
    lnk[MAX_LEN].tok |-> (cnt_r == LEN_W'(1)))
    else $error("wavefront left the chain at the wrong time");

  a_inject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    inj_r.tok |-> busy)
    else $error("wavefront injected while idle");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (first_len_r <= LEN_W'(MAX_LEN)) && (second_len_r <= LEN_W'(MAX_LEN)))
    else $error("word length beyond limit");

  a_no_load_after_second: assert property (@(posedge clk) disable iff (!rst_n)
    (second_len_r != '0) |=> (first_len_r == $past(first_len_r)) || $past(fin_go))
    else $error("first word changed after second word started");

endmodule

`default_nettype wire

>>> sim/ced_distance_checker.sv
`timescale 1ns / 100ps
// Checker for case_insensitive_edit_distance: follows the request and result ports,
// keeps its own copy of the DP row and compares every emitted distance.
// Depends on ced_pkg.
module ced_distance_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [ced_pkg::KIND_W-1:0] in_kind,
  input  logic [ced_pkg::CH_W-1:0]   in_ch,
  input  logic                       out_valid,
  input  logic [ced_pkg::LEN_W-1:0]  out_distance,
  input  logic                       out_overflow,
  output int                         errors,
  output int                         pending
);

  localparam int DIST_CAP = 127;

  typedef struct packed {
    logic [ced_pkg::LEN_W-1:0] distance;
    logic                      overflow;
  } dist_result_t;

  dist_result_t            due_results[$];
  logic [ced_pkg::CH_W-1:0] word_a [ced_pkg::MAX_LEN];
  int                       dist_row [ced_pkg::MAX_LEN + 1];
  int                       len_a;
  int                       len_b;
  logic                     ovf_seen;

  initial begin
    errors = 0;
    pending = 0;
  end

  function automatic bit alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) ? c - 8'd32 : c;
  endfunction

  function automatic bit same_letter(input logic [7:0] a, input logic [7:0] b);
    return alpha(a) && alpha(b) && (fold_upper(a) == fold_upper(b));
  endfunction

  task automatic clear_pair();
    for (int i = 0; i <= ced_pkg::MAX_LEN; i++) begin
      dist_row[i] = i;
    end
    len_a = 0;
    len_b = 0;
    ovf_seen = 1'b0;
  endtask

  task automatic push_second(input logic [7:0] c);
    int diag;
    int prev;
    int best;
    len_b++;
    diag = dist_row[0];
    dist_row[0] = len_b;
    for (int i = 1; i <= len_a; i++) begin
      prev = dist_row[i];
      if (same_letter(word_a[i-1], c)) begin
        dist_row[i] = diag;
      end else begin
        best = diag;
        if (prev < best) best = prev;
        if (dist_row[i-1] < best) best = dist_row[i-1];
        dist_row[i] = best + 1;
      end
      diag = prev;
    end
  endtask

  task automatic apply_request(input logic [ced_pkg::KIND_W-1:0] k, input logic [7:0] c);
    dist_result_t r;
    int d;
    case (k)
      ced_pkg::KIND_LOAD: begin
        if (len_b == 0) begin
          if (len_a < ced_pkg::MAX_LEN) begin
            word_a[len_a] = c;
            len_a++;
          end else begin
            ovf_seen = 1'b1;
          end
        end
      end
      ced_pkg::KIND_SECOND: begin
        if (len_b < ced_pkg::MAX_LEN) begin
          push_second(c);
        end else begin
          ovf_seen = 1'b1;
        end
      end
      ced_pkg::KIND_FINISH: begin
        d = dist_row[len_a];
        if (d > DIST_CAP) d = DIST_CAP;
        r.distance = d[ced_pkg::LEN_W-1:0];
        r.overflow = ovf_seen;
        due_results.insert(due_results.size(), r);
        clear_pair();
      end
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("ERROR at %0t: %s got %0d, want %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    dist_result_t exp_r;
    if (!rst_n) begin
      clear_pair();
      due_results.delete();
    end else begin
      if (out_valid) begin
        if (due_results.size() == 0) begin
          flag_mismatch("unrequested result, distance", int'(out_distance), -1);
        end else begin
          exp_r = due_results.pop_front();
          if (out_distance !== exp_r.distance) begin
            flag_mismatch("distance", int'(out_distance), int'(exp_r.distance));
          end
          if (out_overflow !== exp_r.overflow) begin
            flag_mismatch("overflow", int'(out_overflow), int'(exp_r.overflow));
          end
        end
      end
      if (start && !busy) begin
        apply_request(in_kind, in_ch);
      end
    end
    pending = due_results.size();
  end

endmodule

>>> sim/case_insensitive_edit_distance_tb.sv
`timescale 1ns / 100ps
// Testbench top for case_insensitive_edit_distance: drives directed and random
// word pairs through the request port and prints the verdict.
// Depends on ced_pkg, case_insensitive_edit_distance and ced_distance_checker.
module case_insensitive_edit_distance_tb;

  typedef logic [ced_pkg::KIND_W-1:0] kind_t;
  typedef logic [7:0]                 char_t;

  localparam int TOTAL_ITEMS = 750;
  localparam int CYCLE_LIMIT = 400000;
  localparam kind_t KIND_UNUSED = 2'd3;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic [ced_pkg::KIND_W-1:0] in_kind = '0;
  logic [ced_pkg::CH_W-1:0]   in_ch = '0;
  logic                       busy;
  logic                       out_valid;
  logic [ced_pkg::LEN_W-1:0]  out_distance;
  logic                       out_overflow;
  int                         errors;
  int                         pending;
  int                         idle_pct = 0;
  int                         sent = 0;
  int                         cycles = 0;

  logic [7:0] word_a_q[$];
  logic [7:0] word_b_q[$];
  logic [7:0] bound_chars [6] = '{8'h00, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'hFF};

  always #6 clk = ~clk;

  case_insensitive_edit_distance u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_ch        (in_ch),
    .out_valid    (out_valid),
    .out_distance (out_distance),
    .out_overflow (out_overflow)
  );

  ced_distance_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_ch        (in_ch),
    .out_valid    (out_valid),
    .out_distance (out_distance),
    .out_overflow (out_overflow),
    .errors       (errors),
    .pending      (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("case_insensitive_edit_distance: mismatch");
      $finish;
    end
  end

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(99);
    if (r < 50) return char_t'(($urandom_range(1) ? 8'h41 : 8'h61) + $urandom_range(25));
    if (r < 70) return bound_chars[$urandom_range(5)];
    return char_t'($urandom_range(255));
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 4) return ced_pkg::MAX_LEN + $urandom_range(6, 1);
    if (r < 6) return ced_pkg::MAX_LEN;
    if (r < 12) return $urandom_range(ced_pkg::MAX_LEN, 16);
    return $urandom_range(8);
  endfunction

  task automatic send_req(input logic [ced_pkg::KIND_W-1:0] k, input logic [7:0] c);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_kind <= kind_t'($urandom);
      in_ch <= char_t'($urandom);
      @(negedge clk);
    end
    start <= 1'b1;
    in_kind <= k;
    in_ch <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic run_pair(input bit noisy);
    foreach (word_a_q[i]) send_req(ced_pkg::KIND_LOAD, word_a_q[i]);
    foreach (word_b_q[i]) begin
      send_req(ced_pkg::KIND_SECOND, word_b_q[i]);
      if (noisy && i == 0) begin
        send_req(KIND_UNUSED, rand_byte());
        send_req(ced_pkg::KIND_LOAD, rand_byte());
      end
    end
    if (noisy && word_b_q.size() == 0) send_req(KIND_UNUSED, rand_byte());
    send_req(ced_pkg::KIND_FINISH, char_t'($urandom));
    sent += word_a_q.size() + word_b_q.size() + 1;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
  endtask

  initial begin
    int ph;
    int cur_phase;
    int idx;
    int la;
    int r;
    logic [7:0] c;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    word_a_q = {};
    word_b_q = {};
    run_pair(1'b0);
    word_a_q = '{8'h61, 8'h42};
    word_b_q = '{8'h41, 8'h62};
    run_pair(1'b0);
    word_a_q = '{8'h00, 8'hFF};
    word_b_q = '{8'h00, 8'hFF};
    run_pair(1'b0);
    word_a_q = '{8'h78};
    word_b_q = '{8'h58};
    run_pair(1'b1);
    word_a_q = {};
    word_b_q = '{8'h61, 8'h62};
    run_pair(1'b0);
    word_a_q = '{8'h61, 8'h62, 8'h63};
    word_b_q = {};
    run_pair(1'b0);

    cur_phase = 0;
    idx = 0;
    while (sent < TOTAL_ITEMS) begin
      ph = sent * 4 / TOTAL_ITEMS;
      if (ph > 3) ph = 3;
      if (ph != cur_phase) begin
        hold_until_drained();
        cur_phase = ph;
        idle_pct = (ph == 1) ? 75 : ((ph == 3) ? 9 : 0);
      end
      la = (idx == 0) ? ced_pkg::MAX_LEN + 3 : pick_len();
      word_a_q = {};
      word_b_q = {};
      repeat (la) word_a_q.insert(word_a_q.size(), rand_byte());
      r = $urandom_range(99);
      if (idx == 1) begin
        repeat (ced_pkg::MAX_LEN + 2) word_b_q.insert(word_b_q.size(), rand_byte());
      end else if (r < 70) begin
        // mutate the first word: case flips, substitutions, drops, inserts
        foreach (word_a_q[i]) begin
          c = word_a_q[i];
          r = $urandom_range(99);
          if (r < 55) begin
            word_b_q.insert(word_b_q.size(), $urandom_range(1) ? (c ^ 8'h20) : c);
          end else if (r < 70) begin
            word_b_q.insert(word_b_q.size(), rand_byte());
          end else if (r >= 80) begin
            word_b_q.insert(word_b_q.size(), c);
            word_b_q.insert(word_b_q.size(), rand_byte());
          end
        end
      end else begin
        repeat (pick_len()) word_b_q.insert(word_b_q.size(), rand_byte());
      end
      run_pair($urandom_range(99) < 12);
      idx++;
    end

    hold_until_drained();
    repeat (ced_pkg::MAX_LEN + 8) @(posedge clk);
    if (errors == 0) begin
      $display("case_insensitive_edit_distance: match");
    end else begin
      $display("case_insensitive_edit_distance: mismatch");
    end
    $finish;
  end

endmodule
